>>> sv/lif_alpha_neuron_latency_step_defines.svh
// assertion macros used by the top-level neuron module
`ifndef LIF_ALPHA_NEURON_LATENCY_STEP_DEFINES_SVH
`define LIF_ALPHA_NEURON_LATENCY_STEP_DEFINES_SVH

// same-cycle implication
`define LIFA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lifa assertion failed");

// next-cycle implication
`define LIFA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lifa assertion failed");

`endif

>>> sv/lifa_pkg.sv
package lifa_pkg;

  localparam int COEF_BITS = 24;
  localparam int MUL_W = 34;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W = 48;
  localparam int DEN_W = 35;
  localparam int QUO_W = 64;
  localparam int CNT_W = $clog2(QUO_W);
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SYN_DECAY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYN_CROSS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_EXT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_DSYN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_SYN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LEAK = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 3'd7;

  localparam logic [24:0] RST_SYN_DECAY = 25'd16610194;
  localparam logic [30:0] RST_SYN_CROSS = 31'd2259770;
  localparam logic [30:0] RST_COEF_EXT = 31'd6711;
  localparam logic signed [31:0] RST_COEF_DSYN = 32'sd1228;
  localparam logic signed [31:0] RST_COEF_SYN = 32'sd6545;
  localparam logic signed [31:0] RST_BIAS = 32'sd0;
  localparam logic [24:0] RST_LEAK = 25'd33554;
  localparam logic [24:0] RST_TIME_STEP = 25'd1677722;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_START,
    OP_D0, OP_D1, OP_D2, OP_D3,
    OP_L0, OP_L1,
    OP_H0, OP_H1, OP_H2, OP_H3, OP_H4, OP_DIV, OP_H5,
    OP_S0, OP_S1, OP_S2, OP_S3,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic refr_busy;
    logic below_knee;
    logic at_peak;
    logic den_nonpos;
    logic out_free;
  } status_t;

endpackage

>>> sv/lifa_in_if.sv
interface lifa_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] spike_weight;
  logic signed [31:0] ext_current;

  modport source (output valid, output spike_weight, output ext_current, input ready);
  modport sink (input valid, input spike_weight, input ext_current, output ready);
endinterface

>>> sv/lifa_out_if.sv
interface lifa_out_if;
  logic valid;
  logic ready;
  logic spike;
  logic signed [31:0] membrane;

  modport source (output valid, output spike, output membrane, input ready);
  modport sink (input valid, input spike, input membrane, output ready);
endinterface

>>> sv/lif_alpha_neuron_latency_step.sv
// One leaky integrate-and-fire neuron with alpha synapse, advanced one tick per input item.
// Items are handled one at a time: each takes the refractory path, the path below the -54.4
// knee or the latency-map path before its result is loaded into the output register; the
// latency-map path can run a 64-step restoring divider (one quotient bit per cycle). All
// products go through one shared 34x34 multiplier, one product per cycle. The next item is
// taken while a finished result still waits in the output register. Configuration writes
// take effect at the clock edge they are given on and are meant for idle periods only.
`include "lif_alpha_neuron_latency_step_defines.svh"

module lif_alpha_neuron_latency_step #(
  parameter int REFRACTORY_STEPS = 20,
  parameter int FRACTION_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  lifa_in_if.sink                        in_ch,
  lifa_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [lifa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);

  lifa_pkg::cmd_t cmd;
  lifa_pkg::status_t status;

  lifa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  lifa_dp #(
    .REFRACTORY_STEPS (REFRACTORY_STEPS),
    .FRACTION_BITS    (FRACTION_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_spike_weight (in_ch.spike_weight),
    .in_ext_current  (in_ch.ext_current),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_spike       (out_ch.spike),
    .out_membrane    (out_ch.membrane)
  );

  `LIFA_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready)
  `LIFA_ASSERT_NEXT(a_emit_shows_item, cmd.op == lifa_pkg::OP_EMIT, out_ch.valid)
  `LIFA_ASSERT_IMPL(a_idle_no_work, in_ch.ready,
    cmd.op == lifa_pkg::OP_NONE || cmd.op == lifa_pkg::OP_LOAD)

endmodule

>>> sv/lifa_ctrl.sv
module lifa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lifa_pkg::status_t status,
  output lifa_pkg::cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_D0, S_D1, S_D2, S_D3, S_L0, S_L1,
    S_H0, S_H1, S_H2, S_H3, S_H4, S_DIV, S_H5,
    S_S0, S_S1, S_S2, S_S3, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic [lifa_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    cmd.op = lifa_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = lifa_pkg::OP_LOAD;
          state_nxt = S_START;
        end
      end
      S_START: begin
        cmd.op = lifa_pkg::OP_START;
        state_nxt = status.refr_busy ? S_S0 : S_D0;
      end
      S_D0: begin cmd.op = lifa_pkg::OP_D0; state_nxt = S_D1; end
      S_D1: begin cmd.op = lifa_pkg::OP_D1; state_nxt = S_D2; end
      S_D2: begin cmd.op = lifa_pkg::OP_D2; state_nxt = S_D3; end
      S_D3: begin
        cmd.op = lifa_pkg::OP_D3;
        state_nxt = status.below_knee ? S_L0 : S_H0;
      end
      S_L0: begin cmd.op = lifa_pkg::OP_L0; state_nxt = S_L1; end
      S_L1: begin cmd.op = lifa_pkg::OP_L1; state_nxt = S_S0; end
      S_H0: begin
        cmd.op = lifa_pkg::OP_H0;
        state_nxt = status.at_peak ? S_S0 : S_H1;
      end
      S_H1: begin cmd.op = lifa_pkg::OP_H1; state_nxt = S_H2; end
      S_H2: begin cmd.op = lifa_pkg::OP_H2; state_nxt = S_H3; end
      S_H3: begin
        cmd.op = lifa_pkg::OP_H3;
        state_nxt = status.den_nonpos ? S_S0 : S_H4;
      end
      S_H4: begin
        cmd.op = lifa_pkg::OP_H4;
        cnt_nxt = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op = lifa_pkg::OP_DIV;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == {lifa_pkg::CNT_W{1'b1}}) begin
          state_nxt = S_H5;
        end
      end
      S_H5: begin cmd.op = lifa_pkg::OP_H5; state_nxt = S_S0; end
      S_S0: begin cmd.op = lifa_pkg::OP_S0; state_nxt = S_S1; end
      S_S1: begin cmd.op = lifa_pkg::OP_S1; state_nxt = S_S2; end
      S_S2: begin cmd.op = lifa_pkg::OP_S2; state_nxt = S_S3; end
      S_S3: begin cmd.op = lifa_pkg::OP_S3; state_nxt = S_FIN; end
      S_FIN: begin
        if (status.out_free) begin
          cmd.op = lifa_pkg::OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> sv/lifa_dp.sv
module lifa_dp #(
  parameter int REFRACTORY_STEPS = 20,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  lifa_pkg::cmd_t                       cmd,
  output lifa_pkg::status_t                    status,
  input  logic                                 cfg_we,
  input  logic [lifa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [31:0]                          cfg_data,
  input  logic signed [31:0]                   in_spike_weight,
  input  logic signed [31:0]                   in_ext_current,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic                                 out_spike,
  output logic signed [31:0]                   out_membrane
);

  localparam int MW = lifa_pkg::MUL_W;
  localparam int PW = lifa_pkg::PROD_W;
  localparam int AW = lifa_pkg::ACC_W;
  localparam int DW = lifa_pkg::DEN_W;
  localparam int QW = lifa_pkg::QUO_W;
  localparam int NW = QW + 2;
  localparam longint One = longint'(1) << FRACTION_BITS;
  localparam logic signed [31:0] PEAK_V = 32'(35 * One);
  localparam logic signed [31:0] REST_V = 32'(-70 * One);
  localparam logic signed [31:0] KNEE_V = 32'(-((544 * One + 5) / 10));
  localparam logic signed [31:0] OFF70_V = 32'(70 * One);
  localparam logic signed [31:0] OFF55_V = 32'(55 * One);
  localparam logic signed [31:0] OFF15_V = 32'(15 * One);
  localparam logic [7:0] REFR_LOAD = 8'(REFRACTORY_STEPS);
  localparam logic signed [PW-1:0] RND_HALF = PW'(longint'(1) << (lifa_pkg::COEF_BITS - 1));
  localparam logic signed [AW-1:0] S32_MAX = {{(AW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [AW-1:0] S32_MIN = {{(AW-31){1'b1}}, 31'd0};

  function automatic logic signed [31:0] sat32(input logic signed [AW-1:0] x);
    if (x > S32_MAX) return S32_MAX[31:0];
    if (x < S32_MIN) return S32_MIN[31:0];
    return x[31:0];
  endfunction

  function automatic logic [24:0] unit_sat(input logic [31:0] v);
    if (v[24:0] > 25'h1000000) return 25'h1000000;
    return v[24:0];
  endfunction

  logic [24:0] syn_decay_r, leak_r, tstep_r;
  logic [30:0] syn_cross_r, coef_ext_r;
  logic signed [31:0] coef_dsyn_r, coef_syn_r, bias_r;

  logic signed [31:0] pot_r, cur_r, slope_r, ext_r, w_in_r, e_in_r, v_r;
  logic [7:0] refr_r;
  logic fired_r;
  logic signed [PW-1:0] prod_r;
  logic signed [AW-1:0] acc_r;
  logic signed [MW-1:0] u_r, t_r;
  logic signed [DW-1:0] den_r;
  logic [DW-1:0] rem_r;
  logic [QW-1:0] q_r;
  logic out_valid_r, out_spike_r;
  logic signed [31:0] out_mem_r;

  logic signed [MW-1:0] mul_a, mul_b, u_calc;
  logic signed [PW-1:0] rnd_full;
  logic signed [AW-1:0] rnd, pot_ext, l1_sum;
  logic signed [31:0] acc_sat, l1_v;
  logic [7:0] refr_eff;
  logic signed [DW-1:0] den_calc;
  logic [DW:0] trial, den_u;
  logic signed [NW-1:0] nv;

  assign rnd_full = prod_r + RND_HALF;
  assign rnd = AW'(rnd_full >>> lifa_pkg::COEF_BITS);
  assign pot_ext = AW'(pot_r);
  assign acc_sat = sat32(acc_r);
  assign l1_sum = acc_r - rnd;
  assign l1_v = sat32(l1_sum);
  assign refr_eff = (pot_r == PEAK_V) ? REFR_LOAD : refr_r;
  assign u_calc = MW'(v_r) + MW'(OFF55_V);
  assign den_calc = DW'(OFF15_V) - DW'(t_r);
  assign trial = {rem_r, q_r[QW-1]};
  assign den_u = {1'b0, den_r};
  assign nv = NW'(v_r) + NW'({2'b00, q_r});

  assign status.refr_busy = (refr_eff != 8'd0);
  assign status.below_knee = (pot_r < KNEE_V);
  assign status.at_peak = (acc_sat >= PEAK_V);
  assign status.den_nonpos = den_calc[DW-1] || (den_calc == '0);
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_spike = out_spike_r;
  assign out_membrane = out_mem_r;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      lifa_pkg::OP_D0: begin
        mul_a = MW'(coef_ext_r);
        mul_b = MW'(ext_r) + MW'(bias_r);
      end
      lifa_pkg::OP_D1: begin mul_a = MW'(coef_dsyn_r); mul_b = MW'(slope_r); end
      lifa_pkg::OP_D2: begin mul_a = MW'(coef_syn_r); mul_b = MW'(cur_r); end
      lifa_pkg::OP_L0: begin
        mul_a = MW'(leak_r);
        mul_b = MW'(pot_r) + MW'(OFF70_V);
      end
      lifa_pkg::OP_H1: begin mul_a = MW'(tstep_r); mul_b = u_calc; end
      lifa_pkg::OP_H3: begin mul_a = u_r; mul_b = t_r; end
      lifa_pkg::OP_S0: begin mul_a = MW'(syn_cross_r); mul_b = MW'(slope_r); end
      lifa_pkg::OP_S1: begin mul_a = MW'(syn_decay_r); mul_b = MW'(cur_r); end
      lifa_pkg::OP_S2: begin mul_a = MW'(syn_decay_r); mul_b = MW'(slope_r); end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (cmd.op)
      lifa_pkg::OP_LOAD: begin
        w_in_r <= in_spike_weight;
        e_in_r <= in_ext_current;
      end
      lifa_pkg::OP_D1: acc_r <= rnd;
      lifa_pkg::OP_D2: acc_r <= acc_r + rnd;
      lifa_pkg::OP_D3: acc_r <= acc_r + rnd + pot_ext;
      lifa_pkg::OP_H0: v_r <= acc_sat;
      lifa_pkg::OP_H1: u_r <= u_calc;
      lifa_pkg::OP_H2: t_r <= MW'(rnd);
      lifa_pkg::OP_H3: den_r <= den_calc;
      lifa_pkg::OP_H4: begin
        q_r <= QW'(prod_r);
        rem_r <= '0;
      end
      lifa_pkg::OP_DIV: begin
        if (trial >= den_u) begin
          rem_r <= DW'(trial - den_u);
          q_r <= {q_r[QW-2:0], 1'b1};
        end else begin
          rem_r <= DW'(trial);
          q_r <= {q_r[QW-2:0], 1'b0};
        end
      end
      lifa_pkg::OP_S1: acc_r <= rnd;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      syn_decay_r <= lifa_pkg::RST_SYN_DECAY;
      syn_cross_r <= lifa_pkg::RST_SYN_CROSS;
      coef_ext_r <= lifa_pkg::RST_COEF_EXT;
      coef_dsyn_r <= lifa_pkg::RST_COEF_DSYN;
      coef_syn_r <= lifa_pkg::RST_COEF_SYN;
      bias_r <= lifa_pkg::RST_BIAS;
      leak_r <= lifa_pkg::RST_LEAK;
      tstep_r <= lifa_pkg::RST_TIME_STEP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lifa_pkg::REG_SYN_DECAY: syn_decay_r <= unit_sat(cfg_data);
        lifa_pkg::REG_SYN_CROSS: syn_cross_r <= cfg_data[30:0];
        lifa_pkg::REG_COEF_EXT: coef_ext_r <= cfg_data[30:0];
        lifa_pkg::REG_COEF_DSYN: coef_dsyn_r <= cfg_data;
        lifa_pkg::REG_COEF_SYN: coef_syn_r <= cfg_data;
        lifa_pkg::REG_BIAS: bias_r <= cfg_data;
        lifa_pkg::REG_LEAK: leak_r <= unit_sat(cfg_data);
        lifa_pkg::REG_TIME_STEP: tstep_r <= unit_sat(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pot_r <= REST_V;
      cur_r <= '0;
      slope_r <= '0;
      ext_r <= '0;
      refr_r <= '0;
      fired_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        lifa_pkg::OP_START: begin
          fired_r <= 1'b0;
          if (refr_eff != 8'd0) begin
            pot_r <= REST_V;
            refr_r <= refr_eff - 8'd1;
          end else begin
            refr_r <= refr_eff;
          end
        end
        lifa_pkg::OP_L1: pot_r <= (l1_v < REST_V) ? REST_V : l1_v;
        lifa_pkg::OP_H0: begin
          if (acc_sat >= PEAK_V) begin
            pot_r <= PEAK_V;
            fired_r <= 1'b1;
          end
        end
        lifa_pkg::OP_H3: begin
          if (den_calc[DW-1] || (den_calc == '0)) begin
            pot_r <= PEAK_V;
            fired_r <= 1'b1;
          end
        end
        lifa_pkg::OP_H5: begin
          if (nv >= NW'(PEAK_V)) begin
            pot_r <= PEAK_V;
            fired_r <= 1'b1;
          end else begin
            pot_r <= nv[31:0];
          end
        end
        lifa_pkg::OP_S2: cur_r <= sat32(acc_r + rnd);
        lifa_pkg::OP_S3: begin
          slope_r <= sat32(rnd + AW'(w_in_r));
          ext_r <= e_in_r;
        end
        lifa_pkg::OP_EMIT: out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == lifa_pkg::OP_EMIT) begin
      out_spike_r <= fired_r;
      out_mem_r <= pot_r;
    end
  end

endmodule
